// File: hw/rtl/dipdet_pkg.sv
// ----------------------------------------------------------------------------
// dipdet_pkg
// Shared types, register indexes and reset values for the double-dip detector.
// ----------------------------------------------------------------------------
package dipdet_pkg;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL     = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE      = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIP_MAX   = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_MIN   = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_MAX   = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN  = 4'd7;

	localparam logic signed [15:0] RST_LEVEL     = 16'sd16393;
	localparam logic [14:0]        RST_TOLERANCE = 15'd3279;
	localparam logic [14:0]        RST_RISE      = 15'd4918;
	localparam logic [15:0]        RST_DIP_MAX   = 16'd300;
	localparam logic [15:0]        RST_GAP_MIN   = 16'd80;
	localparam logic [15:0]        RST_GAP_MAX   = 16'd500;
	localparam logic [15:0]        RST_COOLDOWN  = 16'd1000;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_DIP1  = 3'd2;
	localparam logic [2:0] ST_GAP   = 3'd3;
	localparam logic [2:0] ST_DIP2  = 3'd4;
	localparam logic [2:0] ST_COOL  = 3'd5;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_READY = 6'b000010,
		PH_DIP1  = 6'b000100,
		PH_GAP   = 6'b001000,
		PH_DIP2  = 6'b010000,
		PH_COOL  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic               enable;
		logic signed [15:0] level;
		logic [14:0]        tolerance;
		logic [14:0]        rise;
		logic [15:0]        dip_max;
		logic [15:0]        gap_min;
		logic [15:0]        gap_max;
		logic [15:0]        cooldown;
	} cfg_t;

	typedef struct packed {
		logic       detected;
		logic [2:0] state;
		logic       face;
		logic       dip;
	} result_t;

	function automatic logic [2:0] state_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_READY: code = ST_READY;
			PH_DIP1:  code = ST_DIP1;
			PH_GAP:   code = ST_GAP;
			PH_DIP2:  code = ST_DIP2;
			PH_COOL:  code = ST_COOL;
			default:  code = ST_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: hw/rtl/double_dip_gesture_detector.sv
// ----------------------------------------------------------------------------
// double_dip_gesture_detector
// Face-down double-dip gesture detector on raw accelerometer Z samples.
// ----------------------------------------------------------------------------
// One sample enters per clock while in_stall is low; each sample yields
// exactly one result: the sample is held in the input register and its
// result in the result register, with the phase machine stepping as the
// sample leaves the input register. The sustained rate is one sample per
// cycle, limited only by downstream stall. Configuration is taken every
// cycle (cfg_ready is tied high) and must only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module double_dip_gesture_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dipdet_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dipdet_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [15:0]                   z_sample,
	input  logic [31:0]                          timestamp,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 detected,
	output logic [2:0]                           gesture_state,
	output logic                                 is_face_down,
	output logic                                 is_dip
);
	import dipdet_pkg::*;

	cfg_t               cfg;
	logic               disable_wr;
	result_t            res;
	result_t            res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic signed [15:0] z_s1;
	logic [31:0]        ts_s1;
	logic               adv_s2;
	logic               step;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	dipdet_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.disable_wr (disable_wr)
	);

	dipdet_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.disable_wr (disable_wr),
		.step       (step),
		.z_sample   (z_s1),
		.timestamp  (ts_s1),
		.res        (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			z_s1  <= z_sample;
			ts_s1 <= timestamp;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign detected      = res_s2.detected;
	assign gesture_state = res_s2.state;
	assign is_face_down  = res_s2.face;
	assign is_dip        = res_s2.dip;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without downstream backpressure");

	a_detect_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && detected |-> gesture_state == ST_COOL)
		else $error("detect pulse without cooldown state");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("stepped transaction lost before result register");

endmodule

// File: hw/rtl/dipdet_cfg_regs.sv
// ----------------------------------------------------------------------------
// dipdet_cfg_regs
// Configuration register file; flags a write that turns the detector off.
// ----------------------------------------------------------------------------
module dipdet_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dipdet_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dipdet_pkg::CFG_DATA_W-1:0]     cfg_data,
	output dipdet_pkg::cfg_t                      cfg,
	output logic                                  disable_wr
);
	import dipdet_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign cfg_ready  = 1'b1;
	assign wr         = cfg_valid && cfg_ready;
	assign disable_wr = wr && (cfg_index == REG_ENABLE) && !cfg_data[0];
	assign cfg        = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b0;
			cfg_q.level     <= RST_LEVEL;
			cfg_q.tolerance <= RST_TOLERANCE;
			cfg_q.rise      <= RST_RISE;
			cfg_q.dip_max   <= RST_DIP_MAX;
			cfg_q.gap_min   <= RST_GAP_MIN;
			cfg_q.gap_max   <= RST_GAP_MAX;
			cfg_q.cooldown  <= RST_COOLDOWN;
		end else if (wr) begin
			unique case (cfg_index)
				REG_ENABLE:    cfg_q.enable    <= cfg_data[0];
				REG_LEVEL:     cfg_q.level     <= signed'(cfg_data);
				REG_TOLERANCE: cfg_q.tolerance <= cfg_data[14:0];
				REG_RISE:      cfg_q.rise      <= cfg_data[14:0];
				REG_DIP_MAX:   cfg_q.dip_max   <= cfg_data;
				REG_GAP_MIN:   cfg_q.gap_min   <= cfg_data;
				REG_GAP_MAX:   cfg_q.gap_max   <= cfg_data;
				REG_COOLDOWN:  cfg_q.cooldown  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/dipdet_fsm.sv
// ----------------------------------------------------------------------------
// dipdet_fsm
// Threshold compares, elapsed-tick timing and the six-phase gesture machine.
// ----------------------------------------------------------------------------
module dipdet_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dipdet_pkg::cfg_t     cfg,
	input  logic                 disable_wr,
	input  logic                 step,
	input  logic signed [15:0]   z_sample,
	input  logic [31:0]          timestamp,
	output dipdet_pkg::result_t  res
);
	import dipdet_pkg::*;

	phase_t             phase_q;
	phase_t             phase_d;
	phase_t             rest;
	logic [31:0]        mark_q;
	logic               mark_ld;
	logic               det;
	logic signed [16:0] diff;
	logic [16:0]        mag;
	logic signed [17:0] dip_thr;
	logic               face;
	logic               dip;
	logic [31:0]        elapsed;
	logic               dip_over;
	logic               gap_over;
	logic               gap_ok;
	logic               cool_over;

	assign diff    = 17'(z_sample) - 17'(cfg.level);
	assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
	assign face    = mag < {2'b00, cfg.tolerance};
	assign dip_thr = 18'(cfg.level) + signed'({3'b000, cfg.rise});
	assign dip     = 18'(z_sample) > dip_thr;
	assign elapsed = timestamp - mark_q;

	assign dip_over  = elapsed > {16'h0000, cfg.dip_max};
	assign gap_over  = elapsed > {16'h0000, cfg.gap_max};
	assign gap_ok    = elapsed >= {16'h0000, cfg.gap_min};
	assign cool_over = elapsed > {16'h0000, cfg.cooldown};
	assign rest      = face ? PH_READY : PH_IDLE;

	always_comb begin
		phase_d = phase_q;
		mark_ld = 1'b0;
		det     = 1'b0;
		if (!cfg.enable) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_READY: begin
					if (dip) begin
						phase_d = PH_DIP1;
						mark_ld = 1'b1;
					end else if (!face) begin
						phase_d = PH_IDLE;
					end
				end
				PH_DIP1: begin
					if (dip_over) begin
						phase_d = rest;
					end else if (!dip) begin
						phase_d = PH_GAP;
						mark_ld = 1'b1;
					end
				end
				PH_GAP: begin
					if (gap_over) begin
						phase_d = rest;
					end else if (dip && gap_ok) begin
						phase_d = PH_DIP2;
						mark_ld = 1'b1;
					end
				end
				PH_DIP2: begin
					if (dip_over) begin
						phase_d = rest;
					end else if (!dip) begin
						phase_d = PH_COOL;
						mark_ld = 1'b1;
						det     = 1'b1;
					end
				end
				PH_COOL: begin
					if (cool_over) begin
						phase_d = rest;
					end
				end
				default: begin
					phase_d = rest;
				end
			endcase
		end
	end

	assign res.detected = det;
	assign res.state    = state_code(phase_d);
	assign res.face     = face;
	assign res.dip      = dip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mark_q  <= '0;
		end else if (disable_wr) begin
			phase_q <= PH_IDLE;
		end else if (step) begin
			phase_q <= phase_d;
			if (mark_ld) begin
				mark_q <= timestamp;
			end
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register not one-hot");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.enable |-> phase_q == PH_IDLE)
		else $error("detector disabled but phase not idle");

	a_detect_cool: assert property (@(posedge clk) disable iff (!arst_n)
		step && det && !disable_wr |=> phase_q == PH_COOL && mark_q == $past(timestamp))
		else $error("detection did not start cooldown");

endmodule

// File: tb/sv/tb_double_dip_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_double_dip_gesture_detector
// Self-checking bench for the face-down double-dip gesture detector.
// ----------------------------------------------------------------------------
// A short directed table covers the compare boundaries, the disabled block,
// a full gesture, timeouts and timestamp wrap. Random phases follow, each
// with its own register setting (extremes included), driven mostly with
// gesture-shaped samples chosen from the predicted detector phase. Every
// result transaction is checked field by field against the expectation
// queue. Both sides idle and stall at random; one phase runs without gaps.
// ----------------------------------------------------------------------------
module tb_double_dip_gesture_detector;
	import dipdet_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 50;
	localparam int CALM_PHASE     = 5;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE = 4'hF;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_SAMPLE_EXP} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]    data;
		logic signed [15:0]       z;
		logic [31:0]              ts;
		result_t                  want;
	} row_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic signed [15:0]       z_sample  = '0;
	logic [31:0]              timestamp = '0;
	logic                     out_stall = 1'b0;
	logic                     cfg_ready;
	logic                     in_stall;
	logic                     out_valid;
	logic                     detected;
	logic [2:0]               gesture_state;
	logic                     is_face_down;
	logic                     is_dip;

	cfg_t        model_cfg;
	logic [2:0]  model_phase;
	logic [31:0] model_mark;
	result_t     pending_results[$];
	int          fault_count = 0;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;
	row_t        script[$];

	double_dip_gesture_detector DUT (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic result_t next_gesture(input logic signed [15:0] z, input logic [31:0] now);
		int         diff;
		int         mag;
		logic       face;
		logic       dip;
		logic [31:0] elapsed;
		logic [2:0] rest;
		result_t    r;
		diff    = int'(z) - int'($signed(model_cfg.level));
		mag     = diff < 0 ? -diff : diff;
		face    = mag < int'(model_cfg.tolerance);
		dip     = int'(z) > int'($signed(model_cfg.level)) + int'(model_cfg.rise);
		elapsed = now - model_mark;
		rest    = face ? ST_READY : ST_IDLE;
		r       = '0;
		if (!model_cfg.enable) begin
			model_phase = ST_IDLE;
		end else begin
			case (model_phase)
				ST_READY: begin
					if (dip) begin
						model_phase = ST_DIP1;
						model_mark  = now;
					end else if (!face) begin
						model_phase = ST_IDLE;
					end
				end
				ST_DIP1: begin
					if (elapsed > 32'(model_cfg.dip_max)) begin
						model_phase = rest;
					end else if (!dip) begin
						model_phase = ST_GAP;
						model_mark  = now;
					end
				end
				ST_GAP: begin
					if (elapsed > 32'(model_cfg.gap_max)) begin
						model_phase = rest;
					end else if (dip && elapsed >= 32'(model_cfg.gap_min)) begin
						model_phase = ST_DIP2;
						model_mark  = now;
					end
				end
				ST_DIP2: begin
					if (elapsed > 32'(model_cfg.dip_max)) begin
						model_phase = rest;
					end else if (!dip) begin
						r.detected  = 1'b1;
						model_phase = ST_COOL;
						model_mark  = now;
					end
				end
				ST_COOL: begin
					if (elapsed > 32'(model_cfg.cooldown))
						model_phase = rest;
				end
				default: begin
					model_phase = rest;
				end
			endcase
		end
		r.state = model_phase;
		r.face  = face;
		r.dip   = dip;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ENABLE: begin
				model_cfg.enable = data[0];
				if (!data[0])
					model_phase = ST_IDLE;
			end
			REG_LEVEL:     model_cfg.level     = data;
			REG_TOLERANCE: model_cfg.tolerance = data[14:0];
			REG_RISE:      model_cfg.rise      = data[14:0];
			REG_DIP_MAX:   model_cfg.dip_max   = data;
			REG_GAP_MIN:   model_cfg.gap_min   = data;
			REG_GAP_MAX:   model_cfg.gap_max   = data;
			REG_COOLDOWN:  model_cfg.cooldown  = data;
			default: ;
		endcase
	endfunction

	// z inside the face-down window
	function automatic logic signed [15:0] face_z();
		int lvl;
		int tol;
		int lo;
		int hi;
		lvl = int'($signed(model_cfg.level));
		tol = int'(model_cfg.tolerance);
		if (tol == 0)
			return 16'($urandom);
		lo = (lvl - tol + 1 < -32768) ? -32768 : lvl - tol + 1;
		hi = (lvl + tol - 1 > 32767) ? 32767 : lvl + tol - 1;
		return 16'(lo + int'($urandom_range(hi - lo)));
	endfunction

	// z above the dip threshold
	function automatic logic signed [15:0] dip_z();
		int lo;
		lo = int'($signed(model_cfg.level)) + int'(model_cfg.rise) + 1;
		if (lo > 32767)
			return 16'($urandom);
		return 16'(lo + int'($urandom_range(32767 - lo)));
	endfunction

	function automatic int unsigned stretch(input logic [15:0] limit);
		if ($urandom_range(9) == 0)
			return $urandom_range(2 * int'(limit) + 2);
		return $urandom_range(int'(limit) / 3 + 1);
	endfunction

	function automatic row_t sample_row(input logic signed [15:0] z, input logic [31:0] ts);
		return '{ROW_SAMPLE, '0, '0, z, ts, '0};
	endfunction

	function automatic row_t checked_row(input logic signed [15:0] z, input logic [31:0] ts,
	                                     input result_t want);
		return '{ROW_SAMPLE_EXP, '0, '0, z, ts, want};
	endfunction

	function automatic row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
	                                   input logic [CFG_DATA_W-1:0] data);
		return '{ROW_WRITE, idx, data, '0, '0, '0};
	endfunction

	task automatic report(input string what, input int got, input int want);
		fault_count++;
		if (fault_count <= 40)
			$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	task automatic send_sample(input logic signed [15:0] z, input logic [31:0] ts,
	                           input bit typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		z_sample  <= z;
		timestamp <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = next_gesture(z, ts);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	// drop both request lines and wait for every pending result
	task automatic settle();
		@(negedge clk);
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			out_stall <= !calm && ($urandom_range(99) < 16);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result transaction, state", int'(gesture_state), 0);
			end else begin
				want = pending_results.pop_front();
				if (detected !== want.detected)
					report("detected", int'(detected), int'(want.detected));
				if (gesture_state !== want.state)
					report("gesture_state", int'(gesture_state), int'(want.state));
				if (is_face_down !== want.face)
					report("is_face_down", int'(is_face_down), int'(want.face));
				if (is_dip !== want.dip)
					report("is_dip", int'(is_dip), int'(want.dip));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [15:0] z;
		logic [31:0]        now;
		logic [15:0]        lvl;
		logic [15:0]        dmax;
		logic [15:0]        gmin;
		logic [15:0]        gmax;
		logic [15:0]        cool;
		logic [14:0]        tol;
		logic [14:0]        rise;
		logic               en;
		int                 roll;

		model_cfg   = '{1'b0, RST_LEVEL, RST_TOLERANCE, RST_RISE, RST_DIP_MAX,
		                RST_GAP_MIN, RST_GAP_MAX, RST_COOLDOWN};
		model_phase = ST_IDLE;
		model_mark  = '0;

		script = '{
			checked_row(16'sd16393, 32'd5, '{1'b0, ST_IDLE, 1'b1, 1'b0}),
			checked_row(16'sh7FFF, 32'd6, '{1'b0, ST_IDLE, 1'b0, 1'b1}),
			checked_row(16'sh8000, 32'd7, '{1'b0, ST_IDLE, 1'b0, 1'b0}),
			checked_row(16'sd0, 32'd0, '{1'b0, ST_IDLE, 1'b0, 1'b0}),
			checked_row(16'sd13115, 32'hFFFF_FFFF, '{1'b0, ST_IDLE, 1'b1, 1'b0}),
			checked_row(16'sd13114, 32'd8, '{1'b0, ST_IDLE, 1'b0, 1'b0}),
			checked_row(16'sd21312, 32'd9, '{1'b0, ST_IDLE, 1'b0, 1'b1}),
			checked_row(16'sd21311, 32'd10, '{1'b0, ST_IDLE, 1'b0, 1'b0}),
			write_row(REG_NONE, 16'hFFFF),
			write_row(REG_ENABLE, 16'd1),
			sample_row(16'sd16393, 32'd100),
			sample_row(16'sd22000, 32'd110),
			sample_row(16'sd16393, 32'd150),
			sample_row(16'sd22000, 32'd200),
			sample_row(16'sd22000, 32'd250),
			sample_row(16'sd16400, 32'd300),
			sample_row(16'sd16393, 32'd800),
			sample_row(16'sd16393, 32'd1301),
			sample_row(16'sd22000, 32'd1310),
			sample_row(16'sd22000, 32'd1611),
			sample_row(16'sd16393, 32'hFFFF_FFF0),
			sample_row(16'sh7FFF, 32'hFFFF_FFF8),
			sample_row(16'sd16393, 32'h0000_0010),
			write_row(REG_ENABLE, 16'd0),
			checked_row(16'sd16393, 32'h0000_0020, '{1'b0, ST_IDLE, 1'b1, 1'b0}),
			write_row(REG_ENABLE, 16'd1),
			sample_row(16'sd16393, 32'h0000_0030)
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_WRITE: begin
					settle();
					write_reg(script[i].idx, script[i].data);
					settle();
				end
				ROW_SAMPLE:     send_sample(script[i].z, script[i].ts, 1'b0, '0);
				ROW_SAMPLE_EXP: send_sample(script[i].z, script[i].ts, 1'b1, script[i].want);
				default: ;
			endcase
		end

		now = $urandom;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			en = 1'b1;
			case (p)
				0: begin
					lvl  = RST_LEVEL;
					tol  = RST_TOLERANCE;
					rise = RST_RISE;
					dmax = RST_DIP_MAX;
					gmin = RST_GAP_MIN;
					gmax = RST_GAP_MAX;
					cool = RST_COOLDOWN;
				end
				1: begin
					lvl  = 16'h8000;
					tol  = 15'h7FFF;
					rise = '0;
					{dmax, gmin, gmax, cool} = '0;
				end
				2: begin
					lvl  = 16'h7FFF;
					tol  = 15'h7FFF;
					rise = 15'h7FFF;
					{dmax, gmin, gmax, cool} = '1;
				end
				3: begin
					lvl  = '0;
					tol  = 15'd1;
					rise = '0;
					dmax = 16'd5;
					gmin = 16'd2;
					gmax = 16'd10;
					cool = 16'd3;
				end
				default: begin
					lvl  = 16'(int'($urandom_range(40000)) - 20000);
					tol  = 15'($urandom_range(50, 6000));
					rise = 15'($urandom_range(6000));
					dmax = 16'($urandom_range(1, 400));
					gmin = 16'($urandom_range(200));
					gmax = gmin + 16'($urandom_range(600));
					cool = 16'($urandom_range(1500));
					if ($urandom_range(3) == 0) begin
						{lvl, dmax, gmin, gmax, cool} = 80'({$urandom, $urandom, $urandom});
						tol  = 15'($urandom);
						rise = 15'($urandom);
					end
					if (p == 4) begin
						tol = '0;
						en  = 1'b0;
					end
				end
			endcase
			write_reg(REG_LEVEL, lvl);
			write_reg(REG_TOLERANCE, {1'($urandom), tol});
			write_reg(REG_RISE, {1'($urandom), rise});
			write_reg(REG_DIP_MAX, dmax);
			write_reg(REG_GAP_MIN, gmin);
			write_reg(REG_GAP_MAX, gmax);
			write_reg(REG_COOLDOWN, cool);
			write_reg(4'($urandom_range(8, 15)), 16'($urandom));
			write_reg(REG_ENABLE, {15'($urandom), en});
			settle();
			calm = (p == CALM_PHASE);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (roll < 6) begin
					z   = 16'($urandom);
					now = now + $urandom;
				end else begin
					case (model_phase)
						ST_READY: begin
							z   = (roll < 45) ? dip_z() : face_z();
							now = now + $urandom_range(20);
						end
						ST_DIP1, ST_DIP2: begin
							z   = (roll < 55) ? dip_z() : face_z();
							now = now + stretch(model_cfg.dip_max);
						end
						ST_GAP: begin
							z   = (roll < 50) ? dip_z() : face_z();
							now = now + stretch(model_cfg.gap_max);
						end
						ST_COOL: begin
							z   = face_z();
							now = now + stretch(model_cfg.cooldown);
						end
						default: begin
							z   = (roll < 90) ? face_z() : 16'($urandom);
							now = now + $urandom_range(20);
						end
					endcase
				end
				send_sample(z, now, 1'b0, '0);
			end
			calm = 1'b0;
		end

		settle();
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/dipdet_pkg.sv
hw/rtl/dipdet_cfg_regs.sv
hw/rtl/dipdet_fsm.sv
hw/rtl/double_dip_gesture_detector.sv
tb/sv/tb_double_dip_gesture_detector.sv
